>>> hdl/bounded_mru_list_top_assert.svh
// Assertion macros shared by the MRU list RTL.
`ifndef BOUNDED_MRU_LIST_TOP_ASSERT_SVH
`define BOUNDED_MRU_LIST_TOP_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define BMRU_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BMRU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hdl/bmru_pkg.sv
// Types, sizes and codes of the MRU list.
package bmru_pkg;

	localparam int DEPTH     = 32;
	localparam int KEY_W     = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int IN_KEY_W  = 32;
	localparam int OUT_KEY_W = 32;
	localparam int POS_W     = 5;
	localparam int OUT_W     = 40;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [KEY_W-1:0] key_t;

	localparam cnt_t FULL_CNT = cnt_t'(DEPTH);
	localparam cnt_t TAIL_IDX = cnt_t'(DEPTH - 1);

	typedef enum logic [1:0] {
		FN_PUSH   = 2'd0,
		FN_REMOVE = 2'd1,
		FN_DUMP   = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_PRD,
		ST_PWR,
		ST_RRD,
		ST_RWR,
		ST_DRD,
		ST_DEM,
		ST_EMIT
	} state_t;

endpackage

>>> hdl/bounded_mru_list_top.sv
// Bounded move-to-front MRU list of distinct keys, kept in one RAM.
//
// Input channel s_*: one transaction is one command. s_tuser carries the
// command (push, remove, dump), s_tdata the key. A command is taken only
// while the block is idle; an unused command code is dropped silently.
// Output channel m_*: one transaction per result, m_tlast on the final result
// of a command. Push and remove give one result, dump one result per entry
// (newest first), or a single not-found result when the list is empty.
// Keys live in a 32-entry RAM with registered read. A push or
// remove scans the RAM from the front, a read and then a compare per entry
// examined, then shifts by one slot, a read and then a write per entry moved,
// and then presents the result. A dump reads and emits one entry at a time.
// Throughput is one command at a time, set by the single RAM port pair that
// both scan and shift use.
// Reset clears the fill count and the control state; RAM content is left
// as is and never read above the fill count. A stalled receiver holds the
// output register; the block then waits before loading the next result, but
// a finished result in the register does not keep a new command from entering.
module bounded_mru_list_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] item_key
	input  logic [bmru_pkg::IN_KEY_W-1:0] s_tdata,
	// [1:0] func
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] found, [5:1] position, [6] evicted, [38:7] key_out, [39] zero fill
	output logic [bmru_pkg::OUT_W-1:0]    m_tdata,
	output logic                          m_tlast
);

	// Key RAM
	bmru_pkg::key_t mem [bmru_pkg::DEPTH];
	bmru_pkg::key_t rd_data_q;
	logic           rd_en;
	bmru_pkg::idx_t rd_addr;
	logic           wr_en;
	bmru_pkg::idx_t wr_addr;
	bmru_pkg::key_t wr_data;

	// Control
	bmru_pkg::state_t state_q, state_d;
	bmru_pkg::func_t  func_q;
	bmru_pkg::cnt_t   fill_q;
	bmru_pkg::cnt_t   idx_q;
	logic             out_valid_q;

	// Command payload and result under construction
	bmru_pkg::key_t   key_q;
	bmru_pkg::key_t   last_q;
	logic             found_q;
	bmru_pkg::cnt_t   pos_q;
	logic             evict_q;
	bmru_pkg::key_t   drop_q;

	// Output register
	logic                           out_found_q;
	logic [bmru_pkg::POS_W-1:0]     out_pos_q;
	logic                           out_evict_q;
	logic [bmru_pkg::OUT_KEY_W-1:0] out_key_q;
	logic                           out_last_q;

	logic           in_acc;
	logic           out_free;
	logic           hit;
	logic           at_end;
	logic           rm_done;
	logic           dump_last;
	logic           load_res;
	logic           load_dump;
	bmru_pkg::cnt_t idx_inc;
	bmru_pkg::cnt_t idx_dec;

	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign hit       = (rd_data_q == key_q);
	assign idx_inc   = bmru_pkg::cnt_t'(idx_q + 1'b1);
	assign idx_dec   = bmru_pkg::cnt_t'(idx_q - 1'b1);
	assign at_end    = (idx_q == fill_q);
	assign rm_done   = (idx_inc == fill_q);
	assign dump_last = (idx_inc == fill_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmru_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (bmru_pkg::func_t'(s_tuser))
						bmru_pkg::FN_PUSH,
						bmru_pkg::FN_REMOVE: state_d = bmru_pkg::ST_SRD;
						bmru_pkg::FN_DUMP: begin
							state_d = (fill_q == '0) ? bmru_pkg::ST_EMIT : bmru_pkg::ST_DRD;
						end
						default: state_d = bmru_pkg::ST_IDLE;
					endcase
				end
			end
			bmru_pkg::ST_SRD: begin
				if (at_end) begin
					state_d = (func_q == bmru_pkg::FN_PUSH) ? bmru_pkg::ST_PRD : bmru_pkg::ST_EMIT;
				end else begin
					state_d = bmru_pkg::ST_SCMP;
				end
			end
			bmru_pkg::ST_SCMP: begin
				if (hit) begin
					state_d = (func_q == bmru_pkg::FN_PUSH) ? bmru_pkg::ST_PRD : bmru_pkg::ST_RRD;
				end else begin
					state_d = bmru_pkg::ST_SRD;
				end
			end
			bmru_pkg::ST_PRD: state_d = (idx_q == '0) ? bmru_pkg::ST_EMIT : bmru_pkg::ST_PWR;
			bmru_pkg::ST_PWR: state_d = bmru_pkg::ST_PRD;
			bmru_pkg::ST_RRD: state_d = rm_done ? bmru_pkg::ST_EMIT : bmru_pkg::ST_RWR;
			bmru_pkg::ST_RWR: state_d = bmru_pkg::ST_RRD;
			bmru_pkg::ST_DRD: state_d = bmru_pkg::ST_DEM;
			bmru_pkg::ST_DEM: begin
				if (out_free) begin
					state_d = dump_last ? bmru_pkg::ST_IDLE : bmru_pkg::ST_DRD;
				end
			end
			bmru_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = bmru_pkg::ST_IDLE;
				end
			end
			default: state_d = bmru_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: RAM port controls and output-register loads
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = idx_q[bmru_pkg::IDX_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = idx_q[bmru_pkg::IDX_W-1:0];
		wr_data   = rd_data_q;
		load_res  = 1'b0;
		load_dump = 1'b0;
		unique case (state_q)
			bmru_pkg::ST_IDLE: s_tready = 1'b1;
			bmru_pkg::ST_SRD:  rd_en = !at_end;
			bmru_pkg::ST_PRD: begin
				if (idx_q == '0) begin
					wr_en   = 1'b1;
					wr_data = key_q;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_dec[bmru_pkg::IDX_W-1:0];
				end
			end
			bmru_pkg::ST_PWR: wr_en = 1'b1;
			bmru_pkg::ST_RRD: begin
				rd_en   = !rm_done;
				rd_addr = idx_inc[bmru_pkg::IDX_W-1:0];
			end
			bmru_pkg::ST_RWR:  wr_en = 1'b1;
			bmru_pkg::ST_DRD:  rd_en = 1'b1;
			bmru_pkg::ST_DEM:  load_dump = out_free;
			bmru_pkg::ST_EMIT: load_res = out_free;
			default: ;
		endcase
	end

	// Key RAM, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmru_pkg::ST_IDLE;
			func_q      <= bmru_pkg::FN_PUSH;
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res || load_dump) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				bmru_pkg::ST_IDLE: begin
					if (in_acc) begin
						func_q <= bmru_pkg::func_t'(s_tuser);
						idx_q  <= '0;
					end
				end
				bmru_pkg::ST_SRD: begin
					// Miss on push: open the front slot, dropping the tail if full
					if (at_end && func_q == bmru_pkg::FN_PUSH) begin
						if (fill_q == bmru_pkg::FULL_CNT) begin
							idx_q <= bmru_pkg::TAIL_IDX;
						end else begin
							idx_q  <= fill_q;
							fill_q <= bmru_pkg::cnt_t'(fill_q + 1'b1);
						end
					end
				end
				bmru_pkg::ST_SCMP: begin
					if (!hit) begin
						idx_q <= idx_inc;
					end
				end
				bmru_pkg::ST_PWR: idx_q <= idx_dec;
				bmru_pkg::ST_RRD: begin
					if (rm_done) begin
						fill_q <= bmru_pkg::cnt_t'(fill_q - 1'b1);
					end
				end
				bmru_pkg::ST_RWR: idx_q <= idx_inc;
				bmru_pkg::ST_DEM: begin
					if (out_free) begin
						idx_q <= idx_inc;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			bmru_pkg::ST_IDLE: begin
				key_q   <= bmru_pkg::key_t'(s_tdata);
				found_q <= 1'b0;
				pos_q   <= '0;
				evict_q <= 1'b0;
				drop_q  <= '0;
			end
			bmru_pkg::ST_SRD: begin
				if (at_end && func_q == bmru_pkg::FN_PUSH && fill_q == bmru_pkg::FULL_CNT) begin
					evict_q <= 1'b1;
					drop_q  <= last_q;
				end
			end
			bmru_pkg::ST_SCMP: begin
				last_q <= rd_data_q;
				if (hit) begin
					found_q <= 1'b1;
					pos_q   <= idx_q;
				end
			end
			default: ;
		endcase

		if (load_res) begin
			out_found_q <= found_q;
			out_pos_q   <= pos_q[bmru_pkg::POS_W-1:0];
			out_evict_q <= evict_q;
			out_key_q   <= bmru_pkg::OUT_KEY_W'(drop_q);
			out_last_q  <= 1'b1;
		end else if (load_dump) begin
			out_found_q <= 1'b1;
			out_pos_q   <= idx_q[bmru_pkg::POS_W-1:0];
			out_evict_q <= 1'b0;
			out_key_q   <= bmru_pkg::OUT_KEY_W'(rd_data_q);
			out_last_q  <= dump_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_key_q, out_evict_q, out_pos_q, out_found_q};

	`include "bounded_mru_list_top_assert.svh"

	`BMRU_ASSERT_ALWAYS(a_fill_bound, fill_q <= bmru_pkg::FULL_CNT, "fill count above depth")
	`BMRU_ASSERT_IMPL(a_wr_in_list, wr_en, bmru_pkg::cnt_t'(wr_addr) < fill_q, "write above fill count")
	`BMRU_ASSERT_IMPL(a_miss_pos, m_tvalid && !out_found_q, out_pos_q == '0, "miss with nonzero position")
	`BMRU_ASSERT_IMPL(a_evict_miss, m_tvalid && out_evict_q, !out_found_q, "eviction on a hit")

endmodule

>>> tb/bounded_mru_list_checker.sv
// Checker for the MRU list: predicts results from commands, compares output transactions.
module bounded_mru_list_checker
	import bmru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [IN_KEY_W-1:0] s_tdata,
	input  logic [1:0]          s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OUT_W-1:0]    m_tdata,
	input  logic                m_tlast,
	output int                  fails,
	output int                  pending,
	output int                  n_cmds,
	output int                  n_results,
	output int                  n_evicts,
	output int                  peak_fill
);

	// Output transaction as seen on {m_tlast, m_tdata}.
	typedef struct packed {
		logic                 last;
		logic                 pad;
		logic [OUT_KEY_W-1:0] key_out;
		logic                 evicted;
		logic [POS_W-1:0]     position;
		logic                 found;
	} mru_result_t;

	key_t        list_keys [DEPTH];
	int          list_fill;
	mru_result_t due_q [$];
	mru_result_t want;
	mru_result_t got;

	function automatic int locate(key_t k);
		int i;
		for (i = 0; i < list_fill; i++)
			if (list_keys[i] == k)
				return i;
		return list_fill;
	endfunction

	function automatic mru_result_t make_result(logic hit, int pos, logic ev, key_t k,
			logic fin);
		mru_result_t r;
		r          = '0;
		r.found    = hit;
		r.position = POS_W'(pos);
		r.evicted  = ev;
		r.key_out  = OUT_KEY_W'(k);
		r.last     = fin;
		return r;
	endfunction

	// Append one predicted result at the tail of the queue.
	task automatic queue_result(mru_result_t r);
		due_q.insert(due_q.size(), r);
	endtask

	task automatic apply_cmd(func_t f, key_t k);
		int   p;
		int   i;
		key_t dropped;
		logic ev;
		p = locate(k);
		case (f)
			FN_PUSH: begin
				if (p < list_fill) begin
					for (i = p; i > 0; i--)
						list_keys[i] = list_keys[i-1];
					list_keys[0] = k;
					queue_result(make_result(1'b1, p, 1'b0, '0, 1'b1));
				end else begin
					ev      = 1'b0;
					dropped = '0;
					if (list_fill == DEPTH) begin
						ev        = 1'b1;
						dropped   = list_keys[DEPTH-1];
						list_fill = DEPTH - 1;
						n_evicts++;
					end
					for (i = list_fill; i > 0; i--)
						list_keys[i] = list_keys[i-1];
					list_keys[0] = k;
					list_fill++;
					queue_result(make_result(1'b0, 0, ev, dropped, 1'b1));
				end
			end
			FN_REMOVE: begin
				if (p < list_fill) begin
					for (i = p; i + 1 < list_fill; i++)
						list_keys[i] = list_keys[i+1];
					list_fill--;
					queue_result(make_result(1'b1, p, 1'b0, '0, 1'b1));
				end else begin
					queue_result(make_result(1'b0, 0, 1'b0, '0, 1'b1));
				end
			end
			FN_DUMP: begin
				if (list_fill == 0)
					queue_result(make_result(1'b0, 0, 1'b0, '0, 1'b1));
				for (i = 0; i < list_fill; i++)
					queue_result(make_result(1'b1, i, 1'b0, list_keys[i],
						i == list_fill - 1));
			end
			default: ;
		endcase
		if (list_fill > peak_fill)
			peak_fill = list_fill;
	endtask

	task automatic note(string fld, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fld, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_fill = 0;
			due_q.delete();
			fails     = 0;
			pending   = 0;
			n_cmds    = 0;
			n_results = 0;
			n_evicts  = 0;
			peak_fill = 0;
		end else begin
			// results first: a command taken at this edge cannot answer at this edge
			if (m_tvalid && m_tready) begin
				got = {m_tlast, m_tdata};
				if (due_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h last %b",
						$time, m_tdata, m_tlast);
					fails++;
				end else begin
					want = due_q.pop_front();
					note("found", want.found, got.found);
					note("position", want.position, got.position);
					note("evicted", want.evicted, got.evicted);
					note("key_out", want.key_out, got.key_out);
					note("last", want.last, got.last);
					note("pad bit", want.pad, got.pad);
					n_results++;
				end
			end
			if (s_tvalid && s_tready) begin
				n_cmds++;
				apply_cmd(func_t'(s_tuser), s_tdata[KEY_W-1:0]);
			end
			pending = due_q.size();
		end
	end

endmodule

>>> tb/bounded_mru_list_top_tb.sv
// Testbench top for the MRU list: stimulus, output flow control and verdict.
module bounded_mru_list_top_tb;
	import bmru_pkg::*;

	// Worst case is far below this: ~140 commands, and a 32-entry dump also
	// waits on receiver stalls for each result.
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 300;   // long receiver stall, fills the block
	localparam int DRAIN_CYCLES = 200;   // idle edges after the final drain
	localparam int POOL_N       = 24;    // small key pool so pushes and removes hit
	localparam int BURST_N      = 40;    // more distinct keys than DEPTH: forces evictions

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_KEY_W-1:0] s_tdata  = '0;
	logic [1:0]          s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tlast;

	int   fails, pending, n_cmds, n_results, n_evicts, peak_fill;
	int   src_idle  = 0;   // percent of cycles the sender holds back
	int   snk_idle  = 0;   // percent of cycles the receiver deasserts m_tready
	logic hold_req  = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   cycles    = 0;

	key_t key_pool [POOL_N];
	key_t fresh    [BURST_N];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bounded_mru_list_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	bounded_mru_list_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.fails     (fails),
		.pending   (pending),
		.n_cmds    (n_cmds),
		.n_results (n_results),
		.n_evicts  (n_evicts),
		.peak_fill (peak_fill)
	);

	// Receiver: random backpressure, or a long hold-off when the stimulus
	// asks for one. The hold is counted here so the sender keeps offering.
	always @(posedge clk) begin
		if (hold_req && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still due",
				$time, cycles, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one command transaction; returns at the edge where it is taken.
	// Entered at a rising edge, so s_tvalid gets exactly one update per step.
	task automatic offer(func_t f, key_t k);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= k;
		do @(posedge clk); while (!s_tready);
	endtask

	// Mostly pushes and removes on the pool so keys move around inside the
	// list; some dumps, some unused codes, some never-seen keys.
	task automatic random_cmds(int n);
		int   r;
		key_t k;
		repeat (n) begin
			r = $urandom_range(99);
			k = key_pool[$urandom_range(POOL_N-1)];
			if (r < 55)
				offer(FN_PUSH, k);
			else if (r < 78)
				offer(FN_REMOVE, k);
			else if (r < 88)
				offer(FN_DUMP, $urandom);
			else if (r < 93)
				offer(FN_NONE, $urandom);
			else
				offer(FN_PUSH, $urandom);
		end
	endtask

	// Sender goes quiet until every predicted result has arrived. One edge
	// first so the last command is already counted as due.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	initial begin
		int i;
		for (i = 0; i < POOL_N; i++)
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		// low byte keeps the burst keys distinct from each other
		for (i = 0; i < BURST_N; i++)
			fresh[i] = {24'($urandom), 8'(i)};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 36;
		snk_idle = 75;

		// Directed: empty list, key extremes, front hit, move, removes at
		// head and tail, unused code.
		offer(FN_DUMP, '0);                  // empty dump: single not-found
		offer(FN_REMOVE, '0);                // remove from empty list
		offer(FN_PUSH, '0);
		offer(FN_PUSH, '1);
		offer(FN_PUSH, '1);                  // already at front
		offer(FN_PUSH, '0);                  // move from position 1
		offer(FN_PUSH, 32'h8000_0001);
		offer(FN_PUSH, 32'h7FFF_FFFE);
		offer(FN_DUMP, '1);
		offer(FN_REMOVE, 32'h1234_5678);     // absent key
		offer(FN_NONE, 32'hA5A5_A5A5);       // dropped, no result
		offer(FN_REMOVE, '1);                // tail
		offer(FN_REMOVE, 32'h7FFF_FFFE);     // head
		offer(FN_REMOVE, '0);
		offer(FN_REMOVE, 32'h8000_0001);     // list empty again
		offer(FN_DUMP, '0);
		offer(FN_NONE, '1);

		random_cmds(25);

		// Long output stall while distinct keys keep coming: the block backs
		// up and stalls its input, the list fills and starts evicting.
		hold_req <= 1'b1;
		for (i = 0; i < BURST_N; i++)
			offer(FN_PUSH, fresh[i]);
		offer(FN_DUMP, '0);                  // full list, positions 0..31
		offer(FN_PUSH, fresh[BURST_N-DEPTH]);     // oldest entry, position 31
		offer(FN_REMOVE, fresh[BURST_N-DEPTH+1]); // new oldest, position 31
		offer(FN_DUMP, '1);

		src_idle = 75;
		snk_idle = 36;
		random_cmds(25);
		drain();

		src_idle = 0;
		snk_idle = 0;
		random_cmds(25);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands (push, remove, dump, unused code) over three idle mixes",
			n_cmds);
		$display("with one long output stall: %0d results checked, %0d evictions,",
			n_results, n_evicts);
		$display("peak fill %0d/%0d", peak_fill, DEPTH);
		if (fails == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
